// ===== hdl/rau_pkg.sv =====
package rau_pkg;

	// Default sign width of the operands
	localparam int OPERAND_WIDTH = 16;

	// Field widths
	localparam int FIELD_W   = 16;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int RES_NUM_W = 33;
	localparam int RES_DEN_W = 31;

	// Datapath widths: one spare bit holds a zero-extended 16-bit field
	localparam int OPX_W     = FIELD_W + 1;
	localparam int PROD_W    = 2 * OPX_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int MAG_W     = ACC_W - 1;
	localparam int DIV_CNT_W = $clog2(MAG_W + 1);
	localparam int SHIFT_W   = $clog2(MAG_W);

	// Sequencer
	localparam int PC_W = 4;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t STEP_LOAD = '0;

	typedef enum logic [1:0] {
		MODE_ADD,
		MODE_SUB,
		MODE_MUL,
		MODE_DIV
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_DEN_ZERO,
		ST_UNDEF
	} status_t;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_MUL1,
		OP_MUL2,
		OP_MUL3,
		OP_DEN,
		OP_MAG,
		OP_TWOS,
		OP_GCD,
		OP_GFIX,
		OP_DIVN,
		OP_DSTEP,
		OP_STN,
		OP_STD,
		OP_OUT
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_INPUT,
		C_TWOS,
		C_GCD,
		C_DIV_BUSY,
		C_G_ZERO,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		pc_t    target;
		logic   last;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic twos;
		logic gcd_run;
		logic div_busy;
		logic g_zero;
		logic out_busy;
	} flags_t;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [FIELD_W-1:0] a_num;
		logic signed [FIELD_W-1:0] a_den;
		logic signed [FIELD_W-1:0] b_num;
		logic signed [FIELD_W-1:0] b_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [RES_NUM_W-1:0] res_num;
		logic [RES_DEN_W-1:0]        res_den;
		logic [STATUS_W-1:0]         status;
	} rau_out_t;

endpackage

// ===== hdl/rau_stream_if.sv =====
interface rau_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/rau_useq.sv =====
module rau_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  rau_pkg::flags_t flags,
	output rau_pkg::ctrl_t  ctrl,
	output rau_pkg::pc_t    pc
);

	localparam int PC_W = rau_pkg::PC_W;

	localparam rau_pkg::pc_t S_MUL1  = PC_W'(1);
	localparam rau_pkg::pc_t S_MUL2  = PC_W'(2);
	localparam rau_pkg::pc_t S_MUL3  = PC_W'(3);
	localparam rau_pkg::pc_t S_DEN   = PC_W'(4);
	localparam rau_pkg::pc_t S_MAG   = PC_W'(5);
	localparam rau_pkg::pc_t S_TWOS  = PC_W'(6);
	localparam rau_pkg::pc_t S_GCD   = PC_W'(7);
	localparam rau_pkg::pc_t S_GFIX  = PC_W'(8);
	localparam rau_pkg::pc_t S_DIVN  = PC_W'(9);
	localparam rau_pkg::pc_t S_DLOOPN = PC_W'(10);
	localparam rau_pkg::pc_t S_STN   = PC_W'(11);
	localparam rau_pkg::pc_t S_DLOOPD = PC_W'(12);
	localparam rau_pkg::pc_t S_STD   = PC_W'(13);
	localparam rau_pkg::pc_t S_OUT   = PC_W'(14);

	rau_pkg::pc_t pc_q;
	rau_pkg::pc_t pc_d;
	logic         jump;

	function automatic rau_pkg::ctrl_t cw(input rau_pkg::dp_op_t op, input rau_pkg::cond_t cond,
			input rau_pkg::pc_t target, input logic last);
		rau_pkg::ctrl_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		w.last   = last;
		return w;
	endfunction

	// Microcode: a jump goes to target when its condition holds, else falls through
	function automatic rau_pkg::ctrl_t ucode(input rau_pkg::pc_t addr);
		rau_pkg::ctrl_t w;
		unique case (addr)
			rau_pkg::STEP_LOAD: w = cw(rau_pkg::OP_LOAD, rau_pkg::C_NO_INPUT, rau_pkg::STEP_LOAD, 1'b0);
			S_MUL1:   w = cw(rau_pkg::OP_MUL1, rau_pkg::C_NEVER, rau_pkg::STEP_LOAD, 1'b0);
			S_MUL2:   w = cw(rau_pkg::OP_MUL2, rau_pkg::C_NEVER, rau_pkg::STEP_LOAD, 1'b0);
			S_MUL3:   w = cw(rau_pkg::OP_MUL3, rau_pkg::C_NEVER, rau_pkg::STEP_LOAD, 1'b0);
			S_DEN:    w = cw(rau_pkg::OP_DEN, rau_pkg::C_NEVER, rau_pkg::STEP_LOAD, 1'b0);
			S_MAG:    w = cw(rau_pkg::OP_MAG, rau_pkg::C_NEVER, rau_pkg::STEP_LOAD, 1'b0);
			S_TWOS:   w = cw(rau_pkg::OP_TWOS, rau_pkg::C_TWOS, S_TWOS, 1'b0);
			S_GCD:    w = cw(rau_pkg::OP_GCD, rau_pkg::C_GCD, S_GCD, 1'b0);
			S_GFIX:   w = cw(rau_pkg::OP_GFIX, rau_pkg::C_G_ZERO, S_OUT, 1'b0);
			S_DIVN:   w = cw(rau_pkg::OP_DIVN, rau_pkg::C_NEVER, rau_pkg::STEP_LOAD, 1'b0);
			S_DLOOPN: w = cw(rau_pkg::OP_DSTEP, rau_pkg::C_DIV_BUSY, S_DLOOPN, 1'b0);
			S_STN:    w = cw(rau_pkg::OP_STN, rau_pkg::C_NEVER, rau_pkg::STEP_LOAD, 1'b0);
			S_DLOOPD: w = cw(rau_pkg::OP_DSTEP, rau_pkg::C_DIV_BUSY, S_DLOOPD, 1'b0);
			S_STD:    w = cw(rau_pkg::OP_STD, rau_pkg::C_NEVER, rau_pkg::STEP_LOAD, 1'b0);
			S_OUT:    w = cw(rau_pkg::OP_OUT, rau_pkg::C_OUT_BUSY, S_OUT, 1'b1);
			default:  w = cw(rau_pkg::OP_LOAD, rau_pkg::C_NO_INPUT, rau_pkg::STEP_LOAD, 1'b0);
		endcase
		return w;
	endfunction

	always_comb begin
		ctrl = ucode(pc_q);
		unique case (ctrl.cond)
			rau_pkg::C_NEVER:    jump = 1'b0;
			rau_pkg::C_NO_INPUT: jump = !flags.in_valid;
			rau_pkg::C_TWOS:     jump = flags.twos;
			rau_pkg::C_GCD:      jump = flags.gcd_run;
			rau_pkg::C_DIV_BUSY: jump = flags.div_busy;
			rau_pkg::C_G_ZERO:   jump = flags.g_zero;
			rau_pkg::C_OUT_BUSY: jump = flags.out_busy;
			default:             jump = 1'b0;
		endcase
		if (jump) begin
			pc_d = ctrl.target;
		end else if (ctrl.last) begin
			pc_d = rau_pkg::STEP_LOAD;
		end else begin
			pc_d = PC_W'(pc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rau_pkg::STEP_LOAD;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign pc = pc_q;

endmodule

// ===== hdl/rau_dpath.sv =====
module rau_dpath #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rau_pkg::ctrl_t  ctrl,
	output rau_pkg::flags_t flags,
	rau_stream_if.sink      operands,
	rau_stream_if.source    result
);

	localparam int FIELD_W   = rau_pkg::FIELD_W;
	localparam int OPX_W     = rau_pkg::OPX_W;
	localparam int PROD_W    = rau_pkg::PROD_W;
	localparam int ACC_W     = rau_pkg::ACC_W;
	localparam int MAG_W     = rau_pkg::MAG_W;
	localparam int DIV_CNT_W = rau_pkg::DIV_CNT_W;
	localparam int SHIFT_W   = rau_pkg::SHIFT_W;
	localparam int RES_NUM_W = rau_pkg::RES_NUM_W;
	localparam int RES_DEN_W = rau_pkg::RES_DEN_W;

	// Operand extension: sign from bit OPERAND_WIDTH-1, or plain 16-bit value when wider
	logic [FIELD_W-1:0]      raw [4];
	logic signed [OPX_W-1:0] ext [4];

	assign raw[0] = operands.payload.a_num;
	assign raw[1] = operands.payload.a_den;
	assign raw[2] = operands.payload.b_num;
	assign raw[3] = operands.payload.b_den;

	for (genvar i = 0; i < 4; i++) begin : g_ext
		if (OPERAND_WIDTH <= FIELD_W) begin : g_sx
			assign ext[i] = OPX_W'($signed(raw[i][OPERAND_WIDTH-1:0]));
		end else begin : g_zx
			assign ext[i] = $signed({1'b0, raw[i]});
		end
	end

	rau_pkg::mode_t          mode_q;
	logic signed [OPX_W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  num_q, den_q;
	logic [MAG_W-1:0]         mn_q, md_q, x_q, y_q, g_q, qn_q, qd_q;
	logic [MAG_W-1:0]         rem_q, quo_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic [SHIFT_W-1:0]       k_q;
	logic                     neg_q;
	rau_pkg::status_t         status_q;

	logic                     out_v_q;
	rau_pkg::rau_out_t        res_q;

	logic signed [OPX_W-1:0] mul_a, mul_b;
	logic [MAG_W-1:0]        num_mag, den_mag;
	logic [MAG_W-1:0]        x_d, y_d;
	logic [MAG_W:0]          shifted, diff;
	logic                    ge;
	logic [MAG_W-1:0]        qn_signed;
	logic                    out_wr;

	// Shared multiplier operand select
	always_comb begin
		mul_a = ad_q;
		mul_b = bd_q;
		case (ctrl.op)
			rau_pkg::OP_MUL1: begin
				mul_a = an_q;
				mul_b = (mode_q == rau_pkg::MODE_MUL) ? bn_q : bd_q;
			end
			rau_pkg::OP_MUL2: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
			rau_pkg::OP_MUL3: begin
				mul_a = ad_q;
				mul_b = (mode_q == rau_pkg::MODE_DIV) ? bn_q : bd_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
		endcase
	end

	assign num_mag = num_q[ACC_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
	assign den_mag = den_q[ACC_W-1] ? MAG_W'(-den_q) : MAG_W'(den_q);

	// Binary GCD step: drop a factor of two from one side, or subtract and halve
	always_comb begin
		x_d = x_q;
		y_d = y_q;
		if (!x_q[0]) begin
			x_d = x_q >> 1;
		end else if (!y_q[0]) begin
			y_d = y_q >> 1;
		end else if (x_q >= y_q) begin
			x_d = (x_q - y_q) >> 1;
		end else begin
			y_d = (y_q - x_q) >> 1;
		end
	end

	// Restoring divide, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign diff    = shifted - {1'b0, g_q};
	assign ge      = shifted >= {1'b0, g_q};

	assign qn_signed = neg_q ? MAG_W'(-qn_q) : qn_q;

	assign flags.in_valid = operands.valid;
	assign flags.twos     = (x_q != '0) && (y_q != '0) && !x_q[0] && !y_q[0];
	assign flags.gcd_run  = (x_q != '0) && (y_q != '0);
	assign flags.div_busy = cnt_q != DIV_CNT_W'(1);
	assign flags.g_zero   = (x_q | y_q) == '0;
	assign flags.out_busy = out_v_q && !result.ready;

	assign operands.ready = ctrl.op == rau_pkg::OP_LOAD;
	assign out_wr         = (ctrl.op == rau_pkg::OP_OUT) && !flags.out_busy;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			rau_pkg::OP_LOAD: begin
				if (operands.valid) begin
					mode_q <= rau_pkg::mode_t'(operands.payload.mode);
					an_q   <= ext[0];
					ad_q   <= ext[1];
					bn_q   <= ext[2];
					bd_q   <= ext[3];
				end
			end
			rau_pkg::OP_MUL1: begin
				prod_q <= mul_a * mul_b;
			end
			rau_pkg::OP_MUL2: begin
				num_q  <= ACC_W'(prod_q);
				prod_q <= mul_a * mul_b;
			end
			rau_pkg::OP_MUL3: begin
				case (mode_q)
					rau_pkg::MODE_ADD: num_q <= num_q + ACC_W'(prod_q);
					rau_pkg::MODE_SUB: num_q <= num_q - ACC_W'(prod_q);
					default:           num_q <= num_q;
				endcase
				prod_q <= mul_a * mul_b;
			end
			rau_pkg::OP_DEN: begin
				den_q <= ACC_W'(prod_q);
			end
			rau_pkg::OP_MAG: begin
				mn_q  <= num_mag;
				md_q  <= den_mag;
				x_q   <= num_mag;
				y_q   <= den_mag;
				k_q   <= '0;
				qn_q  <= '0;
				qd_q  <= '0;
				neg_q <= (num_q != '0) && (num_q[ACC_W-1] != den_q[ACC_W-1]);
				if (den_q != '0) begin
					status_q <= rau_pkg::ST_OK;
				end else if (num_q != '0) begin
					status_q <= rau_pkg::ST_DEN_ZERO;
				end else begin
					status_q <= rau_pkg::ST_UNDEF;
				end
			end
			rau_pkg::OP_TWOS: begin
				if (flags.twos) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= SHIFT_W'(k_q + 1'b1);
				end
			end
			rau_pkg::OP_GCD: begin
				if (flags.gcd_run) begin
					x_q <= x_d;
					y_q <= y_d;
				end
			end
			rau_pkg::OP_GFIX: begin
				g_q <= (x_q | y_q) << k_q;
			end
			rau_pkg::OP_DIVN: begin
				rem_q <= '0;
				quo_q <= mn_q;
				cnt_q <= DIV_CNT_W'(MAG_W);
			end
			rau_pkg::OP_DSTEP: begin
				rem_q <= ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], ge};
				cnt_q <= DIV_CNT_W'(cnt_q - 1'b1);
			end
			rau_pkg::OP_STN: begin
				qn_q  <= quo_q;
				rem_q <= '0;
				quo_q <= md_q;
				cnt_q <= DIV_CNT_W'(MAG_W);
			end
			rau_pkg::OP_STD: begin
				qd_q <= quo_q;
			end
			rau_pkg::OP_OUT: begin
				if (out_wr) begin
					res_q.res_num <= $signed(qn_signed[RES_NUM_W-1:0]);
					res_q.res_den <= qd_q[RES_DEN_W-1:0];
					res_q.status  <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_wr) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign result.valid   = out_v_q;
	assign result.payload = res_q;

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// Latency grows with t, the count of common factors of two (up to 30), and with s, the
// binary GCD steps (up to about 63); the GCD loop and the two divides set it, and a 0/0
// result skips both divides. One item at a time: a new item is taken only once the last
// result is written to the output register, and that write waits while the result held
// there waits for result.ready.
// Reset: arst_n clears the step counter and the output valid; data registers are not reset.
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
	input logic          clk,
	input logic          arst_n,
	rau_stream_if.sink   operands,
	rau_stream_if.source result
);

	// Microcoded flow:
	//   load   - wait for an item, latch and extend the four operands
	//   mul    - three products on one shared multiplier (product registered),
	//            numerator combined per mode, denominator kept
	//   mag    - magnitudes, result sign, status
	//   twos   - strip common factors of two (counted in k)
	//   gcd    - binary GCD until one side is zero; g = (x | y) << k
	//   divide - numerator and denominator each divided by g (restoring, 1 bit/cycle)
	//   out    - write the output register, then back to load
	// When g is zero (both magnitudes zero) the divides are skipped and 0/0 goes out.

	rau_pkg::ctrl_t  ctrl;
	rau_pkg::flags_t flags;
	rau_pkg::pc_t    pc;

	rau_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl),
		.pc     (pc)
	);

	rau_dpath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.flags    (flags),
		.operands (operands),
		.result   (result)
	);

	// An accepted item always moves the sequencer off the load step
	a_accept_advances: assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.ready |=> pc != rau_pkg::STEP_LOAD)
		else $error("sequencer stayed on load step after accept");

	// A write step with a free output register leaves a valid result
	a_out_written: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == rau_pkg::OP_OUT && !flags.out_busy |=> result.valid)
		else $error("result not valid after output write");

	// A nonzero denominator goes with ok status and only with it
	a_den_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.payload.status == rau_pkg::ST_OK) ==
			(result.payload.res_den != '0)))
		else $error("denominator and status disagree");

	// Undefined result carries a zero numerator
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.status == rau_pkg::ST_UNDEF |->
			result.payload.res_num == '0)
		else $error("undefined result with nonzero numerator");

endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rau_pkg::*;

	// Clock and reset
	logic clk;
	logic arst_n;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Operand and result channels
	rau_stream_if #(.T(rau_in_t))  operands_if ();
	rau_stream_if #(.T(rau_out_t)) result_if ();

	rational_arithmetic_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_if),
		.result   (result_if)
	);

	// Operand items waiting to be offered, and reduced fractions still owed by the block
	rau_in_t  operand_queue[$];
	rau_out_t expected_fractions[$];

	int unsigned errors;
	// Random gaps on both sides; cleared for the closing stretch
	logic        idling_on;

	// Expected reduced fraction for one operand item.
	// Operands are full 16-bit two's complement (operand width equals field width).
	function automatic rau_out_t combine_fractions(rau_in_t op);
		longint            an, ad, bn, bd, rn, rd;
		longint unsigned   mag_n, mag_d, p, q, r, qn, qd;
		logic              neg;
		logic [63:0]       signed_num;
		rau_out_t          y;
		an = op.a_num;
		ad = op.a_den;
		bn = op.b_num;
		bd = op.b_den;
		case (mode_t'(op.mode))
			MODE_ADD: begin
				rn = an * bd + ad * bn;
				rd = ad * bd;
			end
			MODE_SUB: begin
				rn = an * bd - bn * ad;
				rd = ad * bd;
			end
			MODE_MUL: begin
				rn = an * bn;
				rd = ad * bd;
			end
			default: begin
				rn = an * bd;
				rd = ad * bn;
			end
		endcase
		mag_n = (rn < 0) ? longint'(-rn) : rn;
		mag_d = (rd < 0) ? longint'(-rd) : rd;
		// sign lives on the numerator; a zero numerator is never negative
		neg = (rn != 0) && ((rn < 0) != (rd < 0));
		// Euclid on the magnitudes
		p = mag_n;
		q = mag_d;
		while (q != 0) begin
			r = p % q;
			p = q;
			q = r;
		end
		// p == 0 only when both are zero: result 0/0
		if (p == 0) begin
			qn = 0;
			qd = 0;
		end else begin
			qn = mag_n / p;
			qd = mag_d / p;
		end
		signed_num = neg ? (64'd0 - qn) : qn;
		y.res_num = signed_num[RES_NUM_W-1:0];
		y.res_den = qd[RES_DEN_W-1:0];
		if (mag_d != 0)
			y.status = ST_OK;
		else if (mag_n != 0)
			y.status = ST_DEN_ZERO;
		else
			y.status = ST_UNDEF;
		return y;
	endfunction

	// Operand source: holds each item until accepted, random gaps between items while idling_on
	always @(posedge clk or negedge arst_n) begin : drive
		int unsigned send_gap;
		logic        next_valid;
		if (!arst_n) begin
			operands_if.valid   <= 1'b0;
			operands_if.payload <= '0;
			send_gap = 0;
		end else begin
			next_valid = operands_if.valid;
			if (operands_if.valid && operands_if.ready) begin
				expected_fractions.push_back(combine_fractions(operands_if.payload));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap = send_gap - 1;
				end else if (operand_queue.size() != 0) begin
					if (idling_on && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(1, 13) - 1;
					end else begin
						operands_if.payload <= operand_queue.pop_front();
						next_valid = 1'b1;
					end
				end
			end
			operands_if.valid <= next_valid;
		end
	end

	// Result sink: checks each item against the oldest expectation, stalls at random while idling_on,
	// and once holds off for a long stretch so the block backs up onto its input.
	always @(posedge clk or negedge arst_n) begin : watch
		int unsigned stall_left;
		int unsigned results_seen;
		rau_out_t    want;
		rau_out_t    got;
		logic        next_ready;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left = 0;
			results_seen = 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				got = result_if.payload;
				if (expected_fractions.size() == 0) begin
					$display("%0t: unexpected result %0d/%0d status %0d", $time,
						got.res_num, got.res_den, got.status);
					errors++;
				end else begin
					want = expected_fractions.pop_front();
					if (got.res_num !== want.res_num) begin
						$display("%0t: res_num expected %0d got %0d", $time,
							want.res_num, got.res_num);
						errors++;
					end
					if (got.res_den !== want.res_den) begin
						$display("%0t: res_den expected %0d got %0d", $time,
							want.res_den, got.res_den);
						errors++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							want.status, got.status);
						errors++;
					end
				end
				results_seen++;
				// long hold-off in the middle of the random part
				if (results_seen == 400)
					stall_left = 600;
			end
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				next_ready = 1'b0;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			result_if.ready <= next_ready;
		end
	end

	task automatic queue_item(mode_t m, int an, int ad, int bn, int bd);
		rau_in_t item;
		item.mode  = m;
		item.a_num = an[FIELD_W-1:0];
		item.a_den = ad[FIELD_W-1:0];
		item.b_num = bn[FIELD_W-1:0];
		item.b_den = bd[FIELD_W-1:0];
		operand_queue.push_back(item);
	endtask

	// Mix of full-range values, small values (zeros, easy reductions),
	// corners, and values with many factors of two.
	function automatic int random_field();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = $urandom_range(0, 16'hFFFF);
			5, 6, 7:       v = int'($urandom_range(0, 40)) - 20;
			8: begin
				case ($urandom_range(0, 4))
					0: v = 0;
					1: v = 1;
					2: v = -1;
					3: v = 32767;
					default: v = -32768;
				endcase
			end
			default: begin
				v = int'($urandom_range(1, 255)) << $urandom_range(0, 8);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic queue_random(int unsigned count);
		repeat (count)
			queue_item(mode_t'($urandom_range(0, 3)), random_field(), random_field(),
				random_field(), random_field());
	endtask

	// Wait until every queued item has gone in and every result has come out
	task automatic drain();
		while (operand_queue.size() != 0 || operands_if.valid || expected_fractions.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n              = 1'b0;
		operands_if.valid   = 1'b0;
		operands_if.payload = '0;
		result_if.ready     = 1'b0;
		errors              = 0;
		idling_on           = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items
		queue_item(MODE_ADD, 1, 2, 1, 3);
		queue_item(MODE_SUB, 1, 2, 1, 2);               // zero numerator -> 0/1
		queue_item(MODE_ADD, 1, 2, -1, 2);              // cancels to zero
		queue_item(MODE_MUL, -32768, -32768, -32768, -32768);
		queue_item(MODE_MUL, -32768, 1, -32768, 1);     // largest numerator
		queue_item(MODE_DIV, -32768, 1, 1, -32768);
		queue_item(MODE_DIV, 32767, -32768, -32768, 32767);
		queue_item(MODE_ADD, -32768, 1, -32768, 1);
		queue_item(MODE_SUB, 32767, -32768, -32768, 32767);
		queue_item(MODE_ADD, -32768, -32767, -32768, -32768);
		queue_item(MODE_ADD, 32767, 32767, 32767, 32767);
		queue_item(MODE_MUL, 0, 5, 3, 7);
		queue_item(MODE_ADD, 0, -5, 0, 7);              // zero numerator, negative den
		queue_item(MODE_ADD, 3, 0, 1, 2);               // zero denominator -> +1/0
		queue_item(MODE_SUB, -3, 4, 1, 0);              // zero denominator -> -1/0
		queue_item(MODE_DIV, 5, 7, 0, 3);               // divide by zero value
		queue_item(MODE_MUL, 0, 0, 1, 1);               // both zero -> 0/0
		queue_item(MODE_DIV, 0, 3, 0, 5);               // both zero by divide
		queue_item(MODE_SUB, 0, 0, 0, 0);
		queue_item(MODE_MUL, 6, -4, 10, 15);            // -1/1
		queue_item(MODE_DIV, 1, 1, -1, 1);
		queue_item(MODE_MUL, -1, -1, -1, 1);
		queue_item(MODE_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
		queue_item(MODE_DIV, 4096, 8192, 16384, -2048); // many factors of two
		drain();

		// Random part; the sink's long hold-off falls in here
		queue_random(900);
		drain();

		// Closing stretch with no idling
		idling_on <= 1'b0;
		queue_random(350);
		drain();

		// Room for a stray result to show up
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Overall time limit
	initial begin
		#12_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/rau_pkg.sv
hdl/rau_stream_if.sv
hdl/rau_useq.sv
hdl/rau_dpath.sv
hdl/rational_arithmetic_unit.sv
bench/testbench.sv
